>>> design/abpe_pkg.sv
// ----------------------------------------------------------------------------
// abpe_pkg
// Shared types, constants and byte functions for the advertising frame encoder.
// ----------------------------------------------------------------------------
package abpe_pkg;

    // Frame geometry
    localparam int MAX_PAYLOAD = 18;
    localparam int FRAME_BYTES = 32;
    localparam int HDR_BYTES   = 11;
    localparam int CRC_BYTES   = 3;

    // Header and coding constants
    localparam logic [7:0]  HDR_PDU_TYPE = 8'h42;
    localparam logic [7:0]  HDR_LEN_BASE = 8'h09;
    localparam logic [7:0]  AD_LEN       = 8'h02;
    localparam logic [7:0]  AD_TYPE      = 8'h01;
    localparam logic [7:0]  AD_FLAGS     = 8'h05;
    localparam logic [23:0] CRC_INIT     = 24'h555555;
    localparam logic [23:0] CRC_POLY     = 24'h00065B;
    localparam logic [7:0]  WHITEN_TAP   = 8'h11;
    localparam logic [7:0]  SEED_OR      = 8'h02;
    localparam logic [7:0]  CHAN_BASE    = 8'd37;

    // Request codes
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // Configuration register indexes
    localparam int   CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN = 1'b1;
    localparam logic [1:0] CHAN_INVALID = 2'd3;

    // Command passed from front to back
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_ERROR = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] value;   // length on start, byte on data
        logic       last;    // data byte closes the payload
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       error_flag;
    } result_t;

    typedef struct packed {
        logic [7:0] lfsr;
        logic [7:0] data;
    } whiten_t;

    function automatic logic [7:0] rev8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    // CRC-24 update, byte fed LSB first
    function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] b);
        logic [23:0] c;
        logic        top;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            top = c[23];
            c = {c[22:0], 1'b0};
            if (top != b[i]) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Whitening of one byte, LSB first
    function automatic whiten_t whiten(input logic [7:0] lfsr, input logic [7:0] b);
        whiten_t w;
        w.lfsr = lfsr;
        w.data = b;
        for (int i = 0; i < 8; i++) begin
            if (w.lfsr[7]) begin
                w.lfsr = w.lfsr ^ WHITEN_TAP;
                w.data[i] = ~w.data[i];
            end
            w.lfsr = {w.lfsr[6:0], 1'b0};
        end
        return w;
    endfunction

    function automatic logic [7:0] chan_seed(input logic [1:0] ch);
        return rev8(CHAN_BASE + {6'b0, ch}) | SEED_OR;
    endfunction

endpackage

>>> design/ble_advert_packet_encoder.sv
// ----------------------------------------------------------------------------
// ble_advert_packet_encoder
// BLE non-connectable advertising frame encoder, one radio byte per result.
// ----------------------------------------------------------------------------
// Input queue side: push/full. A start request (req_type 0) with a length up
// to 18 yields the 11 header bytes; each payload request (req_type 1) yields
// one byte; the last payload byte, or the header when the length is 0, is
// followed by the 3 CRC bytes and zero padding up to 32 bytes. A bad length
// or stray payload byte yields a single error result with frame_end set.
// Result queue side: empty/pop; out_byte/frame_end/error_flag show the oldest
// result while empty is low.
// Configuration: cfg_valid/cfg_ready (always ready), index 0 is the address,
// index 1 the channel; write only while the block is idle.
// A request is registered in the command queue and its first result in the
// result queue, when the sequencer is idle and the result queue has room.
// Throughput: one result per cycle, set by the back-end sequencer emitting one
// byte a cycle unless the output stalls; payload bytes flow at one per cycle,
// while header, CRC and padding bursts fill the 2-entry command queue and
// raise full. Reset clears both queues and the frame state. A stalled receiver
// fills the 2-entry result queue, halting the sequencer and then the input.
// ----------------------------------------------------------------------------
module ble_advert_packet_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          req_type,
    input  logic [7:0]                    payload_length,
    input  logic [7:0]                    data_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    out_byte,
    output logic                          frame_end,
    output logic                          error_flag,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [abpe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [47:0]                   cfg_data
);

    logic [47:0]       station_address_reg;
    logic [1:0]        channel_index_reg;
    logic              cmd_valid, cmd_pop;
    abpe_pkg::cmd_t    cmd;
    abpe_pkg::result_t res;

    assign cfg_ready = 1'b1;

    // Configuration registers; an invalid channel code is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            station_address_reg <= '0;
            channel_index_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                abpe_pkg::CFG_ADDR:
                begin
                    station_address_reg <= cfg_data;
                end
                abpe_pkg::CFG_CHAN:
                begin
                    if (cfg_data[1:0] != abpe_pkg::CHAN_INVALID) begin
                        channel_index_reg <= cfg_data[1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    abpe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop)
    );

    abpe_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .station_address (station_address_reg),
        .channel_index   (channel_index_reg),
        .empty           (empty),
        .pop             (pop),
        .res_out         (res)
    );

    assign out_byte   = res.out_byte;
    assign frame_end  = res.frame_end;
    assign error_flag = res.error_flag;

endmodule

>>> design/abpe_front.sv
// ----------------------------------------------------------------------------
// abpe_front
// Accepts requests, tracks the open frame and queues classified commands.
// ----------------------------------------------------------------------------
module abpe_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 req_type,
    input  logic [7:0]           payload_length,
    input  logic [7:0]           data_byte,
    output logic                 cmd_valid,
    output abpe_pkg::cmd_t       cmd,
    input  logic                 cmd_pop
);

    logic           frame_open_reg, frame_open_next;
    logic [4:0]     left_reg, left_next;
    abpe_pkg::cmd_t new_cmd;
    abpe_pkg::cmd_t q_mem [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           accept;

    assign full      = (count_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem[rd_ptr_reg];

    // Classify the incoming request against the frame state
    always_comb
    begin
        frame_open_next = frame_open_reg;
        left_next       = left_reg;
        new_cmd.kind    = abpe_pkg::CMD_ERROR;
        new_cmd.value   = '0;
        new_cmd.last    = 1'b0;
        if (req_type == abpe_pkg::REQ_START) begin
            if (payload_length > 8'(abpe_pkg::MAX_PAYLOAD)) begin
                frame_open_next = 1'b0;
                left_next       = '0;
            end else begin
                new_cmd.kind    = abpe_pkg::CMD_START;
                new_cmd.value   = payload_length;
                frame_open_next = (payload_length != 8'd0);
                left_next       = payload_length[4:0];
            end
        end else if (frame_open_reg && left_reg != 5'd0) begin
            new_cmd.kind  = abpe_pkg::CMD_DATA;
            new_cmd.value = data_byte;
            new_cmd.last  = (left_reg == 5'd1);
            left_next     = left_reg - 5'd1;
            if (left_reg == 5'd1) begin
                frame_open_next = 1'b0;
            end
        end
    end

    // Frame tracking and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_open_reg <= 1'b0;
            left_reg       <= '0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= '0;
        end else begin
            if (accept) begin
                frame_open_reg <= frame_open_next;
                left_reg       <= left_next;
                wr_ptr_reg     <= ~wr_ptr_reg;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (accept && !cmd_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (!accept && cmd_pop) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Command storage
    always_ff @(posedge clk)
    begin
        if (accept) begin
            q_mem[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> design/abpe_back.sv
// ----------------------------------------------------------------------------
// abpe_back
// Frame sequencer: header, payload, CRC and padding bytes into a result queue.
// ----------------------------------------------------------------------------
module abpe_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  abpe_pkg::cmd_t       cmd,
    output logic                 cmd_pop,
    input  logic [47:0]          station_address,
    input  logic [1:0]           channel_index,
    output logic                 empty,
    input  logic                 pop,
    output abpe_pkg::result_t    res_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HDR  = 4'b0010,
        S_CRC  = 4'b0100,
        S_PAD  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [3:0]         idx_reg, idx_next;
    logic [4:0]         len_reg, len_next;
    logic [23:0]        crc_reg, crc_next;
    logic [7:0]         lfsr_reg, lfsr_next;
    logic [5:0]         emitted_reg, emitted_next;

    logic               emit, is_err, is_framed, feed_crc, use_seed;
    logic [7:0]         raw_byte;
    logic [7:0]         lfsr_base;
    logic [23:0]        crc_base;
    logic [5:0]         cnt_next;
    abpe_pkg::whiten_t  wht;
    abpe_pkg::result_t  res_new;

    abpe_pkg::result_t  oq_mem [2];
    logic               oq_wr_reg, oq_rd_reg;
    logic [1:0]         oq_count_reg;
    logic               space, out_pop;

    assign space   = (oq_count_reg != 2'd2);
    assign empty   = (oq_count_reg == 2'd0);
    assign out_pop = pop && !empty;
    assign res_out = oq_mem[oq_rd_reg];

    // Sequencer and byte datapath
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        cmd_pop    = 1'b0;
        emit       = 1'b0;
        is_err     = 1'b0;
        is_framed  = 1'b0;
        feed_crc   = 1'b0;
        use_seed   = 1'b0;
        raw_byte   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && space) begin
                    cmd_pop = 1'b1;
                    emit    = 1'b1;
                    case (cmd.kind)
                        abpe_pkg::CMD_START:
                        begin
                            raw_byte   = abpe_pkg::HDR_PDU_TYPE;
                            use_seed   = 1'b1;
                            feed_crc   = 1'b1;
                            is_framed  = 1'b1;
                            len_next   = cmd.value[4:0];
                            idx_next   = 4'd1;
                            state_next = S_HDR;
                        end
                        abpe_pkg::CMD_DATA:
                        begin
                            raw_byte  = cmd.value;
                            feed_crc  = 1'b1;
                            is_framed = 1'b1;
                            if (cmd.last) begin
                                idx_next   = 4'd0;
                                state_next = S_CRC;
                            end
                        end
                        default:
                        begin
                            is_err = 1'b1;
                        end
                    endcase
                end
            end
            S_HDR:
            begin
                if (space) begin
                    emit      = 1'b1;
                    feed_crc  = 1'b1;
                    is_framed = 1'b1;
                    case (idx_reg)
                        4'd1:    raw_byte = abpe_pkg::HDR_LEN_BASE + {3'b0, len_reg};
                        4'd2:    raw_byte = station_address[7:0];
                        4'd3:    raw_byte = station_address[15:8];
                        4'd4:    raw_byte = station_address[23:16];
                        4'd5:    raw_byte = station_address[31:24];
                        4'd6:    raw_byte = station_address[39:32];
                        4'd7:    raw_byte = station_address[47:40];
                        4'd8:    raw_byte = abpe_pkg::AD_LEN;
                        4'd9:    raw_byte = abpe_pkg::AD_TYPE;
                        default: raw_byte = abpe_pkg::AD_FLAGS;
                    endcase
                    if (idx_reg == 4'(abpe_pkg::HDR_BYTES - 1)) begin
                        idx_next   = 4'd0;
                        state_next = (len_reg == 5'd0) ? S_CRC : S_IDLE;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            S_CRC:
            begin
                if (space) begin
                    emit      = 1'b1;
                    is_framed = 1'b1;
                    case (idx_reg)
                        4'd0:    raw_byte = abpe_pkg::rev8(crc_reg[23:16]);
                        4'd1:    raw_byte = abpe_pkg::rev8(crc_reg[15:8]);
                        default: raw_byte = abpe_pkg::rev8(crc_reg[7:0]);
                    endcase
                    if (idx_reg == 4'(abpe_pkg::CRC_BYTES - 1)) begin
                        idx_next   = 4'd0;
                        state_next = (emitted_reg == 6'(abpe_pkg::FRAME_BYTES - 1))
                                     ? S_IDLE : S_PAD;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            S_PAD:
            begin
                if (space) begin
                    emit = 1'b1;
                    if (emitted_reg == 6'(abpe_pkg::FRAME_BYTES - 1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Whitening, CRC and count
        lfsr_base = use_seed ? abpe_pkg::chan_seed(channel_index) : lfsr_reg;
        crc_base  = use_seed ? abpe_pkg::CRC_INIT : crc_reg;
        wht       = abpe_pkg::whiten(lfsr_base, raw_byte);
        cnt_next  = (use_seed ? 6'd0 : emitted_reg) + 6'd1;

        lfsr_next    = lfsr_reg;
        crc_next     = crc_reg;
        emitted_next = emitted_reg;
        if (emit && !is_err) begin
            emitted_next = cnt_next;
            if (is_framed) begin
                lfsr_next = wht.lfsr;
            end
            if (feed_crc) begin
                crc_next = abpe_pkg::crc_feed(crc_base, raw_byte);
            end
        end

        if (is_err) begin
            res_new.out_byte   = '0;
            res_new.frame_end  = 1'b1;
            res_new.error_flag = 1'b1;
        end else begin
            res_new.out_byte   = is_framed ? abpe_pkg::rev8(wht.data) : 8'h00;
            res_new.frame_end  = (cnt_next == 6'(abpe_pkg::FRAME_BYTES));
            res_new.error_flag = 1'b0;
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            len_reg     <= '0;
            crc_reg     <= abpe_pkg::CRC_INIT;
            lfsr_reg    <= '0;
            emitted_reg <= '0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            crc_reg     <= crc_next;
            lfsr_reg    <= lfsr_next;
            emitted_reg <= emitted_next;
        end
    end

    // Result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= '0;
        end else begin
            if (emit) begin
                oq_wr_reg <= ~oq_wr_reg;
            end
            if (out_pop) begin
                oq_rd_reg <= ~oq_rd_reg;
            end
            if (emit && !out_pop) begin
                oq_count_reg <= oq_count_reg + 2'd1;
            end else if (!emit && out_pop) begin
                oq_count_reg <= oq_count_reg - 2'd1;
            end
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (emit) begin
            oq_mem[oq_wr_reg] <= res_new;
        end
    end

endmodule

>>> bench/ble_advert_packet_encoder_test.sv
// ----------------------------------------------------------------------------
// ble_advert_packet_encoder_test
// Self-checking bench for the advertising frame encoder. A byte-level model
// of header, CRC-24, whitening and padding predicts every result, and each
// popped result is compared field by field. Directed cases and back-pressure
// come first, then random frames with random idling on both sides.
// ----------------------------------------------------------------------------
module ble_advert_packet_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    import abpe_pkg::*;

    // DUT signals
    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 push           = 1'b0;
    logic                 full;
    logic                 req_type       = REQ_START;
    logic [7:0]           payload_length = 8'h00;
    logic [7:0]           data_byte      = 8'h00;
    logic                 empty;
    logic                 pop            = 1'b0;
    logic [7:0]           out_byte;
    logic                 frame_end;
    logic                 error_flag;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = CFG_ADDR;
    logic [47:0]          cfg_data       = 48'h0;

    ble_advert_packet_encoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .empty          (empty),
        .pop            (pop),
        .out_byte       (out_byte),
        .frame_end      (frame_end),
        .error_flag     (error_flag),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Encoder model state
    logic [47:0] mdl_address;
    logic [1:0]  mdl_channel;
    logic [23:0] mdl_crc;
    logic [7:0]  mdl_lfsr;
    logic [4:0]  mdl_left;
    logic [5:0]  mdl_emitted;
    logic        mdl_open;
    int          item_bytes;

    result_t     radio_bytes_q[$];

    // Bench control
    int          fail_count    = 0;
    int          report_count  = 0;
    int          random_items  = 0;
    bit          send_steady   = 1'b0;
    bit          recv_steady   = 1'b0;
    int          hold_req      = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("ble_advert_packet_encoder_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the byte encoder
    // ------------------------------------------------------------------------
    function automatic logic [7:0] bit_flip(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    // CRC-24, byte taken LSB first
    function automatic void crc_absorb(input logic [7:0] b);
        logic top;
        for (int i = 0; i < 8; i++)
        begin
            top = mdl_crc[23];
            mdl_crc = {mdl_crc[22:0], 1'b0};
            if (top != b[i])
            begin
                mdl_crc = mdl_crc ^ CRC_POLY;
            end
        end
    endfunction

    function automatic logic [7:0] whiten_advance(input logic [7:0] b);
        logic [7:0] d;
        d = b;
        for (int i = 0; i < 8; i++)
        begin
            if (mdl_lfsr[7])
            begin
                mdl_lfsr = mdl_lfsr ^ WHITEN_TAP;
                d[i] = ~d[i];
            end
            mdl_lfsr = {mdl_lfsr[6:0], 1'b0};
        end
        return d;
    endfunction

    function automatic void emit_raw(input logic [7:0] b);
        result_t r;
        if (item_bytes >= FRAME_BYTES)
        begin
            return;
        end
        mdl_emitted  = mdl_emitted + 6'd1;
        r.out_byte   = b;
        r.frame_end  = (mdl_emitted == FRAME_BYTES);
        r.error_flag = 1'b0;
        radio_bytes_q.push_back(r);
        item_bytes++;
    endfunction

    function automatic void emit_coded(input logic [7:0] b, input bit in_crc);
        if (in_crc)
        begin
            crc_absorb(b);
        end
        emit_raw(bit_flip(whiten_advance(b)));
    endfunction

    // CRC bytes then zero padding
    function automatic void close_frame();
        logic [23:0] c;
        c = mdl_crc;
        emit_coded(bit_flip(c[23:16]), 1'b0);
        emit_coded(bit_flip(c[15:8]), 1'b0);
        emit_coded(bit_flip(c[7:0]), 1'b0);
        while (mdl_emitted < FRAME_BYTES && item_bytes < FRAME_BYTES)
        begin
            emit_raw(8'h00);
        end
        mdl_open = 1'b0;
        mdl_left = '0;
    endfunction

    function automatic void emit_error();
        result_t r;
        r.out_byte   = 8'h00;
        r.frame_end  = 1'b1;
        r.error_flag = 1'b1;
        radio_bytes_q.push_back(r);
    endfunction

    function automatic void encode_request(input logic req, input logic [7:0] len,
                                           input logic [7:0] data);
        item_bytes = 0;
        if (req == REQ_START)
        begin
            if (len > MAX_PAYLOAD)
            begin
                mdl_open = 1'b0;
                mdl_left = '0;
                emit_error();
                return;
            end
            mdl_crc     = CRC_INIT;
            mdl_lfsr    = bit_flip(CHAN_BASE + {6'b0, mdl_channel}) | SEED_OR;
            mdl_emitted = '0;
            mdl_left    = len[4:0];
            mdl_open    = 1'b1;
            emit_coded(HDR_PDU_TYPE, 1'b1);
            emit_coded(HDR_LEN_BASE + len, 1'b1);
            for (int i = 0; i < 6; i++)
            begin
                emit_coded(mdl_address[8*i +: 8], 1'b1);
            end
            emit_coded(AD_LEN, 1'b1);
            emit_coded(AD_TYPE, 1'b1);
            emit_coded(AD_FLAGS, 1'b1);
            if (mdl_left == 0)
            begin
                close_frame();
            end
            return;
        end
        // payload byte
        if (!mdl_open || mdl_left == 0)
        begin
            emit_error();
            return;
        end
        emit_coded(data, 1'b1);
        mdl_left = mdl_left - 5'd1;
        if (mdl_left == 0)
        begin
            close_frame();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random pop, hold-off, compare with the oldest prediction
    // ------------------------------------------------------------------------
    task automatic check_result();
        result_t want;
        if (radio_bytes_q.size() == 0)
        begin
            fail_count++;
            if (report_count < 10)
            begin
                report_count++;
                $display("unexpected result: out_byte %02h frame_end %0b error_flag %0b",
                         out_byte, frame_end, error_flag);
            end
            return;
        end
        want = radio_bytes_q.pop_front();
        if (out_byte !== want.out_byte || frame_end !== want.frame_end ||
            error_flag !== want.error_flag)
        begin
            fail_count++;
            if (report_count < 10)
            begin
                report_count++;
                $display("mismatch: exp out_byte %02h frame_end %0b error_flag %0b, got %02h %0b %0b",
                         want.out_byte, want.frame_end, want.error_flag,
                         out_byte, frame_end, error_flag);
            end
        end
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
            begin
                pop <= recv_steady || ($urandom_range(99) >= 32);
            end
            @(posedge clk);
            if (pop && !empty)
            begin
                check_result();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // push stays high after a transfer so back-to-back requests need no gap;
    // anything that stops sending lowers it first.
    task automatic send_request(input logic req, input logic [7:0] len,
                                input logic [7:0] data);
        if (!send_steady)
        begin
            while ($urandom_range(99) < 32)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
        push           <= 1'b1;
        req_type       <= req;
        payload_length <= len;
        data_byte      <= data;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        encode_request(req, len, data);
        random_items++;
    endtask

    task automatic send_frame(input int len, input int bytes_sent);
        send_request(REQ_START, 8'(len), 8'($urandom));
        for (int i = 0; i < bytes_sent; i++)
        begin
            send_request(REQ_PAYLOAD, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge clk);
        while (radio_bytes_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // cfg_valid stays high across back-to-back writes; end_config lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == CFG_ADDR)
        begin
            mdl_address = value;
        end
        else if (value[1:0] != CHAN_INVALID)
        begin
            mdl_channel = value[1:0];
        end
    endtask

    task automatic end_config();
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [47:0] addr, input logic [1:0] ch);
        drain_results();
        write_reg(CFG_ADDR, addr);
        write_reg(CFG_CHAN, {46'($urandom), ch});
        end_config();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        // empty payload with reset address and channel 37
        send_frame(0, 0);
    endtask

    task automatic test_extreme_settings();
        apply_settings(48'hFFFF_FFFF_FFFF, 2'd2);
        send_request(REQ_START, 8'd2, 8'hFF);
        send_request(REQ_PAYLOAD, 8'hFF, 8'hFF);
        send_request(REQ_PAYLOAD, 8'h00, 8'h00);
        apply_settings(48'h0, 2'd1);
        send_request(REQ_START, 8'd1, 8'h00);
        send_request(REQ_PAYLOAD, 8'h00, 8'hA5);
    endtask

    task automatic test_errors();
        // stray byte after a closed frame, then oversize lengths
        send_request(REQ_PAYLOAD, 8'h00, 8'h00);
        send_request(REQ_START, 8'd19, 8'h00);
        send_request(REQ_START, 8'd255, 8'hFF);
        // oversize start closes an open frame; following byte is stray
        send_request(REQ_START, 8'd2, 8'h00);
        send_request(REQ_PAYLOAD, 8'h00, 8'h3C);
        send_request(REQ_START, 8'd200, 8'h00);
        send_request(REQ_PAYLOAD, 8'h80, 8'hC3);
    endtask

    task automatic test_restart_in_frame();
        send_request(REQ_START, 8'd3, 8'h00);
        send_request(REQ_PAYLOAD, 8'h00, 8'h5A);
        send_request(REQ_START, 8'd0, 8'h00);
    endtask

    task automatic test_channel_three_ignored();
        drain_results();
        write_reg(CFG_CHAN, 48'h1);
        write_reg(CFG_CHAN, {46'($urandom), CHAN_INVALID});
        end_config();
        send_frame(0, 0);
    endtask

    task automatic test_backpressure();
        drain_results();
        send_steady = 1'b1;
        hold_req    = 300;
        send_frame(MAX_PAYLOAD, MAX_PAYLOAD);
        send_frame(0, 0);
        send_steady = 1'b0;
        drain_results();
    endtask

    task automatic test_random_traffic();
        int phase;
        int kind;
        int len;
        phase = 0;
        while (random_items < 160)
        begin
            case (phase)
                0: apply_settings(48'h0, 2'd0);
                1: apply_settings(48'hFFFF_FFFF_FFFF, 2'd2);
                default: apply_settings(48'({$urandom, $urandom}), 2'($urandom_range(2)));
            endcase
            // one phase runs with no idling on either side
            send_steady = (phase == 2);
            recv_steady = (phase == 2);
            repeat (4)
            begin
                kind = $urandom_range(99);
                len  = ($urandom_range(3) == 0) ? $urandom_range(MAX_PAYLOAD)
                                                : $urandom_range(5);
                if (kind < 70)
                begin
                    send_frame(len, len);
                end
                else if (kind < 80)
                begin
                    // abandoned frame, next start restarts
                    send_frame(len + 1, $urandom_range(len));
                end
                else if (kind < 88)
                begin
                    send_request(REQ_PAYLOAD, 8'($urandom), 8'($urandom));
                end
                else if (kind < 95)
                begin
                    send_request(REQ_START, 8'($urandom_range(255, MAX_PAYLOAD + 1)),
                                 8'($urandom));
                end
                else
                begin
                    send_request(1'($urandom), 8'($urandom), 8'($urandom));
                end
            end
            send_steady = 1'b0;
            recv_steady = 1'b0;
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mdl_address = '0;
        mdl_channel = '0;
        mdl_crc     = CRC_INIT;
        mdl_lfsr    = '0;
        mdl_left    = '0;
        mdl_emitted = '0;
        mdl_open    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_extreme_settings();
        test_errors();
        test_restart_in_frame();
        test_channel_three_ignored();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && radio_bytes_q.size() == 0)
        begin
            $display("ble_advert_packet_encoder_test: PASS");
        end
        else
        begin
            $display("ble_advert_packet_encoder_test: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
design/abpe_pkg.sv
design/abpe_front.sv
design/abpe_back.sv
design/ble_advert_packet_encoder.sv
bench/ble_advert_packet_encoder_test.sv
